>>> src/hcio_pkg.sv
// shared types and constants of the home computer i/o register block
package hcio_pkg;

  // item kinds
  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_PRESS   = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_JOY     = 3'd4,
    KIND_TICK    = 3'd5
  } kind_t;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_KEY_VEC  = 2'd0;
  localparam logic [1:0] CFG_ALT_VEC  = 2'd1;
  localparam logic [1:0] CFG_CPU_REGS = 2'd2;

  // bus word addresses (octal)
  localparam logic [15:0] A_KSTAT   = 16'o177660;
  localparam logic [15:0] A_KDATA   = 16'o177662;
  localparam logic [15:0] A_SCROLL  = 16'o177664;
  localparam logic [15:0] A_CPU0    = 16'o177700;
  localparam logic [15:0] A_CPU1    = 16'o177702;
  localparam logic [15:0] A_CPU2    = 16'o177704;
  localparam logic [15:0] A_TRELOAD = 16'o177706;
  localparam logic [15:0] A_TCOUNT  = 16'o177710;
  localparam logic [15:0] A_TCTL    = 16'o177712;
  localparam logic [15:0] A_PAR     = 16'o177714;
  localparam logic [15:0] A_SYS     = 16'o177716;

  // fixed processor register read values
  localparam logic [15:0] CPU0_VALUE = 16'o177740;
  localparam logic [15:0] CPU1_VALUE = 16'o177777;
  localparam logic [15:0] CPU2_VALUE = 16'o177440;

  // timer control bits
  localparam int unsigned T_STOP_BIT  = 0;
  localparam int unsigned T_WRAP_BIT  = 1;
  localparam int unsigned T_EXPEN_BIT = 2;
  localparam int unsigned T_ONE_BIT   = 3;
  localparam int unsigned T_RUN_BIT   = 4;
  localparam int unsigned T_EXP_BIT   = 7;
  localparam logic [7:0]  TCTL_READ_HIGH = 8'o377;

  // reset values
  localparam logic [8:0] KEY_VEC_RESET = 9'd48;
  localparam logic [8:0] ALT_VEC_RESET = 9'd188;
  localparam logic [9:0] SCROLL_RESET  = 10'o1330;
  localparam logic [9:0] SCROLL_MASK   = 10'o1377;

endpackage

>>> src/home_computer_io_register_block.sv
// top level of the home computer i/o register block
//
// i/o register block of a small 16-bit home computer. each request on the
// in_ channel is one of: a bus read, a bus write, a key press, a key release,
// a joystick update or a timer tick. every request gives exactly one result
// on the out_ channel: read data, a keyboard interrupt with its vector, an
// unknown-address flag, a redraw flag and the current palette, scroll and
// parallel port values.
// the cfg_ port writes the key vectors and the processor register enable
// with no handshake; the user must write it only while the block is idle;
// the block itself does not enforce this. a request's result is registered
// at its accept edge. throughput: one request per cycle while out_ready is
// high, set by the single state update each request makes when accepted.
// the result register is the only storage between the channels: in_ready is
// high while the result register is empty or being emptied in that cycle, so
// a stalled receiver holds off one request and no more.
// reset (rst_n low at a clock edge) empties the result register and puts the
// keyboard, palette, scroll, timer and system registers to their power-up
// values; the cfg_ registers go back to their defaults.
module home_computer_io_register_block
  import hcio_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_address,
  input  logic [15:0] in_write_data,
  input  logic [7:0]  in_key_code,
  input  logic        in_alt_key,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic        out_irq_request,
  output logic [8:0]  out_irq_vector,
  output logic        out_unknown_access,
  output logic        out_redraw,
  output logic [3:0]  out_palette_number,
  output logic [9:0]  out_scroll_word,
  output logic [15:0] out_parallel_out
);

  // configuration registers
  logic [8:0]  key_vector_r;
  logic [8:0]  alt_key_vector_r;
  logic        cpu_regs_enable_r;

  // block state
  logic        kbd_mask_r,        kbd_mask_nxt;
  logic        kbd_ready_r,       kbd_ready_nxt;
  logic [6:0]  kbd_code_r,        kbd_code_nxt;
  logic [8:0]  deferred_vector_r, deferred_vector_nxt;
  logic        deferred_pending_r, deferred_pending_nxt;
  logic [15:0] palette_word_r,    palette_word_nxt;
  logic [9:0]  scroll_reg_r,      scroll_reg_nxt;
  logic [7:0]  joystick_in_r,     joystick_in_nxt;
  logic [15:0] parallel_word_r,   parallel_word_nxt;
  logic        system_ready_r,    system_ready_nxt;
  logic        no_key_down_r,     no_key_down_nxt;
  logic [15:0] timer_reload_r,    timer_reload_nxt;
  logic [15:0] timer_count_r,     timer_count_nxt;
  logic [7:0]  timer_control_r,   timer_control_nxt;
  logic [6:0]  prescale_count_r,  prescale_count_nxt;
  logic [15:0] unknown_count_r,   unknown_count_nxt;

  // result register
  logic        out_valid_r;
  logic [15:0] rd_r;
  logic        irq_r;
  logic [8:0]  vec_r;
  logic        unk_r;
  logic        redraw_r;

  // per-request results
  logic [15:0] rd;
  logic        irq;
  logic [8:0]  vec;
  logic        unk;
  logic        redraw;

  logic        accept;
  logic [9:0]  scroll_new;
  logic [8:0]  press_vec;
  logic [6:0]  pre_inc;
  logic [6:0]  pre_limit;
  logic [15:0] count_dec;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign scroll_new = in_write_data[9:0] & SCROLL_MASK;
  assign press_vec  = in_alt_key ? alt_key_vector_r : key_vector_r;
  assign pre_inc    = prescale_count_r + 7'd1;
  assign count_dec  = timer_count_r - 16'd1;

  // prescale divide selected by control bits 6..5
  always_comb begin
    case (timer_control_r[6:5])
      2'd1:    pre_limit = 7'd16;
      2'd2:    pre_limit = 7'd4;
      2'd3:    pre_limit = 7'd64;
      default: pre_limit = 7'd1;
    endcase
  end

  always_comb begin
    kbd_mask_nxt         = kbd_mask_r;
    kbd_ready_nxt        = kbd_ready_r;
    kbd_code_nxt         = kbd_code_r;
    deferred_vector_nxt  = deferred_vector_r;
    deferred_pending_nxt = deferred_pending_r;
    palette_word_nxt     = palette_word_r;
    scroll_reg_nxt       = scroll_reg_r;
    joystick_in_nxt      = joystick_in_r;
    parallel_word_nxt    = parallel_word_r;
    system_ready_nxt     = system_ready_r;
    no_key_down_nxt      = no_key_down_r;
    timer_reload_nxt     = timer_reload_r;
    timer_count_nxt      = timer_count_r;
    timer_control_nxt    = timer_control_r;
    prescale_count_nxt   = prescale_count_r;
    unknown_count_nxt    = unknown_count_r;
    rd     = '0;
    irq    = 1'b0;
    vec    = '0;
    unk    = 1'b0;
    redraw = 1'b0;

    case (in_kind)
      KIND_READ: begin
        unique case (in_address)
          A_KSTAT:   rd = {8'd0, kbd_ready_r, kbd_mask_r, 6'd0};
          A_KDATA: begin
            // reading the code frees the keyboard and drops a held interrupt
            kbd_ready_nxt        = 1'b0;
            deferred_pending_nxt = 1'b0;
            deferred_vector_nxt  = '0;
            rd = {9'd0, kbd_code_r};
          end
          A_SCROLL:  rd = {6'd0, scroll_reg_r};
          A_TRELOAD: rd = timer_reload_r;
          A_TCOUNT:  rd = timer_count_r;
          A_TCTL:    rd = {TCTL_READ_HIGH, timer_control_r};
          A_PAR:     rd = {8'd0, joystick_in_r};
          A_SYS: begin
            // bit 7 is the motor-stopped flag, always set
            rd = {8'd0, 1'b1, no_key_down_r, 3'd0, system_ready_r, 2'd0};
            system_ready_nxt = 1'b0;
          end
          A_CPU0, A_CPU1, A_CPU2: begin
            if (cpu_regs_enable_r) begin
              if (in_address == A_CPU0) begin
                rd = CPU0_VALUE;
              end else if (in_address == A_CPU1) begin
                rd = CPU1_VALUE;
              end else begin
                rd = CPU2_VALUE;
              end
            end else begin
              unk = 1'b1;
              unknown_count_nxt = unknown_count_r + 16'd1;
            end
          end
          default: begin
            unk = 1'b1;
            unknown_count_nxt = unknown_count_r + 16'd1;
          end
        endcase
      end
      KIND_WRITE: begin
        unique case (in_address)
          A_KSTAT: begin
            kbd_mask_nxt = in_write_data[6];
            // lifting the mask releases a held key interrupt
            if (kbd_mask_r && !in_write_data[6] && deferred_pending_r) begin
              irq = 1'b1;
              vec = deferred_vector_r;
              deferred_pending_nxt = 1'b0;
              deferred_vector_nxt  = '0;
            end
          end
          A_KDATA: begin
            palette_word_nxt = in_write_data;
            redraw = 1'b1;
          end
          A_SCROLL: begin
            if (scroll_new != scroll_reg_r) begin
              scroll_reg_nxt = scroll_new;
              redraw = 1'b1;
            end
          end
          A_TRELOAD: timer_reload_nxt = in_write_data;
          A_TCOUNT:  ;
          A_TCTL: begin
            timer_count_nxt    = timer_reload_r;
            prescale_count_nxt = '0;
            timer_control_nxt  = in_write_data[7:0];
          end
          A_PAR:     parallel_word_nxt = in_write_data;
          A_SYS:     system_ready_nxt = 1'b1;
          default: begin
            unk = 1'b1;
            unknown_count_nxt = unknown_count_r + 16'd1;
          end
        endcase
      end
      KIND_PRESS: begin
        no_key_down_nxt  = 1'b0;
        system_ready_nxt = 1'b1;
        // a key while one is waiting is dropped
        if (!kbd_ready_r) begin
          kbd_code_nxt  = in_key_code[6:0];
          kbd_ready_nxt = 1'b1;
          if (!kbd_mask_r) begin
            irq = 1'b1;
            vec = press_vec;
          end else begin
            deferred_vector_nxt  = press_vec;
            deferred_pending_nxt = 1'b1;
          end
        end
      end
      KIND_RELEASE: begin
        no_key_down_nxt  = 1'b1;
        system_ready_nxt = 1'b1;
      end
      KIND_JOY: joystick_in_nxt = in_write_data[7:0];
      KIND_TICK: begin
        if (timer_control_r[T_STOP_BIT]) begin
          // stopped timer follows the reload value
          timer_count_nxt = timer_reload_r;
        end else if (timer_control_r[T_RUN_BIT]) begin
          prescale_count_nxt = pre_inc;
          if (pre_inc >= pre_limit) begin
            prescale_count_nxt = '0;
            timer_count_nxt    = count_dec;
            if (count_dec == 16'd0 && !timer_control_r[T_WRAP_BIT]) begin
              // expiry: reload, stop if one-shot, flag if enabled
              timer_count_nxt = timer_reload_r;
              if (timer_control_r[T_ONE_BIT]) begin
                timer_control_nxt[T_RUN_BIT] = 1'b0;
              end
              if (timer_control_r[T_EXPEN_BIT]) begin
                timer_control_nxt[T_EXP_BIT] = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vector_r      <= KEY_VEC_RESET;
      alt_key_vector_r  <= ALT_VEC_RESET;
      cpu_regs_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_VEC:  key_vector_r      <= cfg_data;
        CFG_ALT_VEC:  alt_key_vector_r  <= cfg_data;
        CFG_CPU_REGS: cpu_regs_enable_r <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // block state, updated once per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbd_mask_r         <= 1'b1;
      kbd_ready_r        <= 1'b0;
      kbd_code_r         <= '0;
      deferred_vector_r  <= '0;
      deferred_pending_r <= 1'b0;
      palette_word_r     <= '0;
      scroll_reg_r       <= SCROLL_RESET;
      joystick_in_r      <= '0;
      parallel_word_r    <= '0;
      system_ready_r     <= 1'b0;
      no_key_down_r      <= 1'b1;
      timer_reload_r     <= '0;
      timer_count_r      <= '0;
      timer_control_r    <= 8'd1;
      prescale_count_r   <= '0;
      unknown_count_r    <= '0;
    end else if (accept) begin
      kbd_mask_r         <= kbd_mask_nxt;
      kbd_ready_r        <= kbd_ready_nxt;
      kbd_code_r         <= kbd_code_nxt;
      deferred_vector_r  <= deferred_vector_nxt;
      deferred_pending_r <= deferred_pending_nxt;
      palette_word_r     <= palette_word_nxt;
      scroll_reg_r       <= scroll_reg_nxt;
      joystick_in_r      <= joystick_in_nxt;
      parallel_word_r    <= parallel_word_nxt;
      system_ready_r     <= system_ready_nxt;
      no_key_down_r      <= no_key_down_nxt;
      timer_reload_r     <= timer_reload_nxt;
      timer_count_r      <= timer_count_nxt;
      timer_control_r    <= timer_control_nxt;
      prescale_count_r   <= prescale_count_nxt;
      unknown_count_r    <= unknown_count_nxt;
    end
  end

  // result register: filled on accept, emptied when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r     <= rd;
      irq_r    <= irq;
      vec_r    <= vec;
      unk_r    <= unk;
      redraw_r <= redraw;
    end
  end

  // palette, scroll and parallel fields follow the state left by the request
  assign out_valid          = out_valid_r;
  assign out_read_data      = rd_r;
  assign out_irq_request    = irq_r;
  assign out_irq_vector     = vec_r;
  assign out_unknown_access = unk_r;
  assign out_redraw         = redraw_r;
  assign out_palette_number = palette_word_r[11:8];
  assign out_scroll_word    = scroll_reg_r;
  assign out_parallel_out   = parallel_word_r;

endmodule
